// ===== design/assert_macros.svh =====
// Assertion macros used by the checker in wpi_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds while reset is low: when ante is true, cons is true in the same cycle.
`define WPI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Holds at every edge: when ante is true, cons is true in the next cycle.
`define WPI_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/wpi_pkg.sv =====
package wpi_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_CHK,
      ST_CORDIC,
      ST_GAIN_X,
      ST_GAIN_Y,
      ST_SR_RD,
      ST_SR_CMP,
      ST_HI_RD,
      ST_LO_RD,
      ST_DIV_INIT,
      ST_DIV,
      ST_MUL_E,
      ST_MUL_N
   } state_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ABOVE    = 2'd1;
   localparam logic [1:0] STATUS_REJECTED = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   localparam int CORDIC_STEPS = 16;
   localparam logic signed [17:0] GAIN_Q16 = 18'sd39797;

   function automatic logic signed [21:0] atan_units(input logic [3:0] step);
      logic signed [21:0] val;
      case (step)
         4'd0:    val = 22'sd1152000;
         4'd1:    val = 22'sd680065;
         4'd2:    val = 22'sd359328;
         4'd3:    val = 22'sd182400;
         4'd4:    val = 22'sd91554;
         4'd5:    val = 22'sd45822;
         4'd6:    val = 22'sd22916;
         4'd7:    val = 22'sd11459;
         4'd8:    val = 22'sd5730;
         4'd9:    val = 22'sd2865;
         4'd10:   val = 22'sd1432;
         4'd11:   val = 22'sd716;
         4'd12:   val = 22'sd358;
         4'd13:   val = 22'sd179;
         4'd14:   val = 22'sd90;
         4'd15:   val = 22'sd45;
         default: val = 22'sd0;
      endcase
      return val;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
      logic signed [15:0] r;
      if (v > 21'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -21'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== design/wpi_ram.sv =====
module wpi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/wind_profile_interpolator_unit.sv =====
// Wind profile table with linear interpolation in height. Every item gives exactly one
// result, shown for one cycle on rsp_valid; the receiver cannot stall it. A load whose
// index or speed check fails, and a query at height zero or on an empty table, answer
// in the cycle after start. An accepted load runs the 16-step CORDIC that turns speed and
// direction into components, then a gain step for each component. A query runs a binary
// search over the single table memory, each probe a read state and a compare state,
// then the restoring divider that forms the blend ratio one bit per cycle. The table
// needs no clearing after reset.
module wind_profile_interpolator_unit #(
   parameter int TABLE_DEPTH = 64,
   parameter int RATIO_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic [5:0]         req_entry_index,
   input  logic [21:0]        req_entry_height,
   input  logic [14:0]        req_entry_speed,
   input  logic [15:0]        req_entry_direction,
   input  logic [21:0]        req_query_height,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_wind_east,
   output logic signed [15:0] rsp_wind_north,
   output logic [1:0]         rsp_status
);
   import wpi_pkg::*;

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int EW   = 54;
   localparam int BPW  = 17 + RATIO_BITS + 2;
   localparam int DCW  = $clog2(RATIO_BITS + 2);

   state_type state_ff, state_in;
   logic [5:0]        idx_ff, idx_in;
   logic [21:0]       eh_ff, eh_in;
   logic [14:0]       sp_ff, sp_in;
   logic [15:0]       dir_ff, dir_in;
   logic [21:0]       q_ff, q_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic signed [32:0] x_ff, x_in, y_ff, y_in;
   logic signed [25:0] z_ff, z_in;
   logic [3:0]        step_ff, step_in;
   logic              neg_ff, neg_in;
   logic signed [19:0] gx_ff, gx_in;
   logic [21:0]       hh_ff, hh_in, hl_ff, hl_in;
   logic signed [15:0] he_ff, he_in, hn_ff, hn_in, le_ff, le_in, ln_ff, ln_in;
   logic [23:0]       rem_ff, rem_in, dv_ff, dv_in;
   logic [RATIO_BITS:0] quo_ff, quo_in;
   logic [DCW-1:0]    dcnt_ff, dcnt_in;
   logic signed [15:0] ew_ff, ew_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_east_ff, rsp_east_in, rsp_north_ff, rsp_north_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [21:0]   rd_height;
   logic signed [15:0] rd_east, rd_north;

   logic signed [16:0] dir_mod, theta;
   logic               fold_neg;
   logic signed [25:0] z_init;
   logic signed [32:0] mul_src;
   logic signed [50:0] gain_prod;
   logic signed [19:0] gain_out;
   logic [CW:0]        mid_sum;
   logic signed [22:0] num, den;
   logic [47:0]        den_ext;
   logic [24:0]        trial;
   logic               trial_ge;
   logic signed [15:0] blend_hi, blend_lo;
   logic signed [16:0] blend_dif;
   logic signed [BPW-1:0] blend_prod;
   logic signed [19:0] blend_sum;
   logic signed [15:0] blend_val;

   wpi_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_height = rd_data[53:32];
   assign rd_east   = rd_data[31:16];
   assign rd_north  = rd_data[15:0];

   always_comb begin
      dir_mod  = (dir_ff >= 16'd36000) ? $signed({1'b0, dir_ff - 16'd36000})
                                       : $signed({1'b0, dir_ff});
      theta    = (dir_mod > 17'sd18000) ? dir_mod - 17'sd36000 : dir_mod;
      fold_neg = 1'b0;
      if (theta > 17'sd9000) begin
         theta    = theta - 17'sd18000;
         fold_neg = 1'b1;
      end else if (theta < -17'sd9000) begin
         theta    = theta + 17'sd18000;
         fold_neg = 1'b1;
      end
      z_init = 26'(theta) <<< 8;
   end

   assign mul_src   = (state_ff == ST_GAIN_X) ? x_ff : y_ff;
   assign gain_prod = 51'(mul_src) * 51'(GAIN_Q16) + (51'sd1 <<< 29);
   assign gain_out  = gain_prod[49:30];

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign num     = $signed({1'b0, q_ff}) - $signed({1'b0, hl_ff});
   assign den     = $signed({1'b0, hh_ff}) - $signed({1'b0, hl_ff});
   assign den_ext = 48'(hh_ff - hl_ff);
   assign trial    = {rem_ff, quo_ff[RATIO_BITS]};
   assign trial_ge = trial >= {1'b0, dv_ff};

   assign blend_hi   = (state_ff == ST_MUL_E) ? he_ff : hn_ff;
   assign blend_lo   = (state_ff == ST_MUL_E) ? le_ff : ln_ff;
   assign blend_dif  = 17'(blend_hi) - 17'(blend_lo);
   assign blend_prod = BPW'(blend_dif) * $signed({1'b0, quo_ff})
                       + (BPW'(1) <<< (RATIO_BITS - 1));
   assign blend_sum  = 20'(blend_lo) + 20'($signed(blend_prod[BPW-1:RATIO_BITS]));
   assign blend_val  = sat16(21'(blend_sum));

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      eh_in         = eh_ff;
      sp_in         = sp_ff;
      dir_in        = dir_ff;
      q_in          = q_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      gx_in         = gx_ff;
      hh_in         = hh_ff;
      he_in         = he_ff;
      hn_in         = hn_ff;
      hl_in         = hl_ff;
      le_in         = le_ff;
      ln_in         = ln_ff;
      rem_in        = rem_ff;
      dv_in         = dv_ff;
      quo_in        = quo_ff;
      dcnt_in       = dcnt_ff;
      ew_in         = ew_ff;
      rsp_valid_in  = 1'b0;
      rsp_east_in   = rsp_east_ff;
      rsp_north_in  = rsp_north_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(idx_ff);
      wr_data       = '0;
      rd_addr       = mid_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in       = req_entry_index;
               eh_in        = req_entry_height;
               sp_in        = req_entry_speed;
               dir_in       = req_entry_direction;
               q_in         = req_query_height;
               rsp_east_in  = '0;
               rsp_north_in = '0;
               if (req_action == ACTION_LOAD) begin
                  if (int'(req_entry_index) > int'(count_ff) ||
                      int'(req_entry_index) >= TABLE_DEPTH) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_EMPTY;
                  end else if (req_entry_height == '0 && req_entry_speed != '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_REJECTED;
                  end else if (req_entry_index != '0) begin
                     state_in = ST_LD_RD;
                  end else begin
                     state_in = ST_LD_CHK;
                     step_in  = 4'd15;
                  end
               end else begin
                  if (req_query_height == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_OK;
                  end else if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     lo_in    = '0;
                     hi_in    = count_ff;
                     state_in = ST_SR_RD;
                  end
               end
            end
         end
         ST_LD_RD: begin
            rd_addr  = AW'(idx_ff - 6'd1);
            step_in  = 4'd0;
            state_in = ST_LD_CHK;
         end
         ST_LD_CHK: begin
            if (step_ff == 4'd0 && rd_height >= eh_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_REJECTED;
               state_in      = ST_IDLE;
            end else begin
               x_in     = 33'(sp_ff) <<< 14;
               y_in     = '0;
               z_in     = z_init;
               neg_in   = fold_neg;
               step_in  = 4'd0;
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (z_ff >= 0) begin
               x_in = x_ff - (y_ff >>> step_ff);
               y_in = y_ff + (x_ff >>> step_ff);
               z_in = z_ff - 26'(atan_units(step_ff));
            end else begin
               x_in = x_ff + (y_ff >>> step_ff);
               y_in = y_ff - (x_ff >>> step_ff);
               z_in = z_ff + 26'(atan_units(step_ff));
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(CORDIC_STEPS - 1)) begin
               state_in = ST_GAIN_X;
            end
         end
         ST_GAIN_X: begin
            gx_in    = gain_out;
            state_in = ST_GAIN_Y;
         end
         ST_GAIN_Y: begin
            wr_en         = 1'b1;
            wr_data       = {eh_ff,
                             sat16(neg_ff ? 21'(gain_out) : -21'(gain_out)),
                             sat16(neg_ff ? 21'(gx_ff) : -21'(gx_ff))};
            count_in      = CW'(idx_ff) + CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            state_in      = ST_IDLE;
         end
         ST_SR_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[CW:1];
               rd_addr  = mid_sum[AW:1];
               state_in = ST_SR_CMP;
            end else if (lo_ff >= count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_ABOVE;
               state_in      = ST_IDLE;
            end else begin
               rd_addr  = lo_ff[AW-1:0];
               state_in = ST_HI_RD;
            end
         end
         ST_SR_CMP: begin
            if (rd_height < q_ff) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_SR_RD;
         end
         ST_HI_RD: begin
            hh_in    = rd_height;
            he_in    = rd_east;
            hn_in    = rd_north;
            rd_addr  = AW'(lo_ff - CW'(1));
            state_in = ST_LO_RD;
         end
         ST_LO_RD: begin
            if (lo_ff == '0) begin
               hl_in = '0;
               le_in = '0;
               ln_in = '0;
            end else begin
               hl_in = rd_height;
               le_in = rd_east;
               ln_in = rd_north;
            end
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            if (den <= 0 || num >= den) begin
               quo_in   = (RATIO_BITS + 1)'(1) << RATIO_BITS;
               state_in = ST_MUL_E;
            end else if (num <= 0) begin
               quo_in   = '0;
               state_in = ST_MUL_E;
            end else begin
               rem_in   = 24'(num) + 24'(den_ext >> (RATIO_BITS + 1));
               quo_in   = den_ext[RATIO_BITS:0];
               dv_in    = {1'b0, den[21:0], 1'b0};
               dcnt_in  = DCW'(RATIO_BITS + 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = trial_ge ? 24'(trial - {1'b0, dv_ff}) : trial[23:0];
            quo_in  = {quo_ff[RATIO_BITS-1:0], trial_ge};
            dcnt_in = dcnt_ff - DCW'(1);
            if (dcnt_ff == DCW'(1)) begin
               state_in = ST_MUL_E;
            end
         end
         ST_MUL_E: begin
            ew_in    = blend_val;
            state_in = ST_MUL_N;
         end
         ST_MUL_N: begin
            rsp_valid_in  = 1'b1;
            rsp_east_in   = ew_ff;
            rsp_north_in  = blend_val;
            rsp_status_in = STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      eh_ff         <= eh_in;
      sp_ff         <= sp_in;
      dir_ff        <= dir_in;
      q_ff          <= q_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      step_ff       <= step_in;
      neg_ff        <= neg_in;
      gx_ff         <= gx_in;
      hh_ff         <= hh_in;
      he_ff         <= he_in;
      hn_ff         <= hn_in;
      hl_ff         <= hl_in;
      le_ff         <= le_in;
      ln_ff         <= ln_in;
      rem_ff        <= rem_in;
      dv_ff         <= dv_in;
      quo_ff        <= quo_in;
      dcnt_ff       <= dcnt_in;
      ew_ff         <= ew_in;
      rsp_east_ff   <= rsp_east_in;
      rsp_north_ff  <= rsp_north_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_wind_east  = rsp_east_ff;
   assign rsp_wind_north = rsp_north_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== design/wpi_checker.sv =====
`include "assert_macros.svh"

module wpi_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [15:0] rsp_wind_east,
   input logic signed [15:0] rsp_wind_north,
   input logic [1:0]         rsp_status
);
   import wpi_pkg::*;

   `WPI_ASSERT_NEXT(a_reset_idle, clock, reset, !busy && !rsp_valid)
   `WPI_ASSERT_NEXT(a_accept_progress, clock, !reset && start && !busy, busy || rsp_valid)
   `WPI_ASSERT_SAME(a_error_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_wind_east == 16'sd0 && rsp_wind_north == 16'sd0)
   `WPI_ASSERT_SAME(a_result_when_idle, clock, reset, rsp_valid, !busy)

endmodule

bind wind_profile_interpolator_unit wpi_checker u_wpi_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_wind_east  (rsp_wind_east),
   .rsp_wind_north (rsp_wind_north),
   .rsp_status     (rsp_status)
);

// ===== tb/sv/wind_profile_checker.sv =====
`timescale 1ns / 1ps

module wind_profile_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_action,
   input  logic [5:0]         req_entry_index,
   input  logic [21:0]        req_entry_height,
   input  logic [14:0]        req_entry_speed,
   input  logic [15:0]        req_entry_direction,
   input  logic [21:0]        req_query_height,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_wind_east,
   input  logic signed [15:0] rsp_wind_north,
   input  logic [1:0]         rsp_status,
   output int                 error_count,
   output int                 pending_count
);
   import wpi_pkg::*;

   typedef struct {
      logic signed [15:0] east;
      logic signed [15:0] north;
      logic [1:0]         status;
   } wind_answer_type;

   localparam int DEPTH = 64;
   localparam int FRAC_BITS = 16;

   const longint rotation_angle [16] = '{1152000, 680065, 359328, 182400, 91554, 45822,
      22916, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};

   logic [21:0]        heights [DEPTH];
   logic signed [15:0] easts [DEPTH];
   logic signed [15:0] norths [DEPTH];
   int                 entries;
   wind_answer_type    answers [$];

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic void wind_vector(input int sp, input int dir,
                                       output logic signed [15:0] ve,
                                       output logic signed [15:0] vn);
      longint theta, x, y, z, nx;
      bit flip;
      theta = dir % 36000;
      flip = 0;
      if (theta > 18000) theta -= 36000;
      if (theta > 9000) begin
         theta -= 18000;
         flip = 1;
      end else if (theta < -9000) begin
         theta += 18000;
         flip = 1;
      end
      x = longint'(sp) * 16384;
      y = 0;
      z = theta * 256;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= rotation_angle[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += rotation_angle[i];
         end
         x = nx;
      end
      x = (x * 39797 + (longint'(1) << 29)) >>> 30;
      y = (y * 39797 + (longint'(1) << 29)) >>> 30;
      if (flip) begin
         x = -x;
         y = -y;
      end
      ve = clamp16(-y);
      vn = clamp16(-x);
   endfunction

   function automatic wind_answer_type predict_wind(input logic act, input int idx,
                                                    input int eh, input int sp,
                                                    input int dir, input int q);
      wind_answer_type a;
      int lo, hi, mid;
      longint h_hi, h_lo, le, ln, den, num, ratio, one, half;
      logic signed [15:0] ve, vn;
      a.east = 0;
      a.north = 0;
      a.status = STATUS_OK;
      one = longint'(1) << FRAC_BITS;
      half = longint'(1) << (FRAC_BITS - 1);
      if (act == ACTION_LOAD) begin
         if (idx > entries || idx >= DEPTH) begin
            a.status = STATUS_EMPTY;
         end else if ((idx > 0 && heights[idx-1] >= eh) || (eh == 0 && sp != 0)) begin
            a.status = STATUS_REJECTED;
         end else begin
            wind_vector(sp, dir, ve, vn);
            heights[idx] = eh;
            easts[idx] = ve;
            norths[idx] = vn;
            entries = idx + 1;
         end
      end else if (q == 0) begin
         a.status = STATUS_OK;
      end else if (entries == 0) begin
         a.status = STATUS_EMPTY;
      end else begin
         lo = 0;
         hi = entries;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (heights[mid] < q) lo = mid + 1;
            else hi = mid;
         end
         if (lo >= entries) begin
            a.status = STATUS_ABOVE;
         end else begin
            h_hi = heights[lo];
            h_lo = 0;
            le = 0;
            ln = 0;
            if (lo > 0) begin
               h_lo = heights[lo-1];
               le = easts[lo-1];
               ln = norths[lo-1];
            end
            den = h_hi - h_lo;
            num = longint'(q) - h_lo;
            if (den <= 0 || num >= den) ratio = one;
            else if (num <= 0) ratio = 0;
            else ratio = (num * one * 2 + den) / (2 * den);
            a.east = clamp16(le + (((longint'(easts[lo]) - le) * ratio + half) >>> FRAC_BITS));
            a.north = clamp16(ln + (((longint'(norths[lo]) - ln) * ratio + half)
                                    >>> FRAC_BITS));
         end
      end
      return a;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      pending_count = 0;
      entries = 0;
   end

   always @(posedge clock) begin
      wind_answer_type w;
      if (reset) begin
         entries = 0;
         answers.delete();
      end else begin
         if (rsp_valid) begin
            if (answers.size() == 0) begin
               report_mismatch("unexpected item, status", rsp_status, -1);
            end else begin
               w = answers.pop_front();
               if (rsp_wind_east !== w.east) report_mismatch("east", rsp_wind_east, w.east);
               if (rsp_wind_north !== w.north)
                  report_mismatch("north", rsp_wind_north, w.north);
               if (rsp_status !== w.status) report_mismatch("status", rsp_status, w.status);
            end
         end
         if (start && !busy) begin
            answers.push_back(predict_wind(req_action, req_entry_index, req_entry_height,
               req_entry_speed, req_entry_direction, req_query_height));
         end
      end
      pending_count = answers.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import wpi_pkg::*;

   localparam int ITEM_TARGET = 1600;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HEIGHT_MAX = 4194303;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic               req_action = ACTION_LOAD;
   logic [5:0]         req_entry_index = 0;
   logic [21:0]        req_entry_height = 0;
   logic [14:0]        req_entry_speed = 0;
   logic [15:0]        req_entry_direction = 0;
   logic [21:0]        req_query_height = 0;
   logic               rsp_valid;
   logic signed [15:0] rsp_wind_east;
   logic signed [15:0] rsp_wind_north;
   logic [1:0]         rsp_status;
   int                 error_count;
   int                 pending_count;
   int                 cycles = 0;
   int                 sent = 0;
   bit                 gaps_on = 1;
   int                 profile [64];
   int                 profile_len = 0;

   always #5 clock = ~clock;

   wind_profile_interpolator_unit uut (.*);

   wind_profile_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("wind_profile_interpolator_unit regression: fail");
         $finish;
      end
   end

   task automatic send_item(input logic act, input int idx, input int eh, input int sp,
                            input int dir, input int q);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      start <= 1;
      req_action <= act;
      req_entry_index <= idx;
      req_entry_height <= eh;
      req_entry_speed <= sp;
      req_entry_direction <= dir;
      req_query_height <= q;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      @(posedge clock);
      sent++;
   endtask

   task automatic load_entry(input int idx, input int eh, input int sp, input int dir);
      send_item(ACTION_LOAD, idx, eh, sp, dir, $urandom_range(0, HEIGHT_MAX));
   endtask

   task automatic ask_height(input int q);
      send_item(ACTION_QUERY, $urandom_range(0, 63), $urandom_range(0, HEIGHT_MAX),
                $urandom_range(0, 32767), $urandom_range(0, 65535), q);
   endtask

   task automatic build_profile();
      int n, prev, room, cap, h;
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 64);
      prev = 0;
      case ($urandom_range(0, 2))
         0: cap = 200;
         1: cap = 50000;
         default: cap = HEIGHT_MAX;
      endcase
      for (int i = 0; i < n; i++) begin
         room = (HEIGHT_MAX - prev) / (n - i);
         if (room > cap) room = cap;
         if (room < 1) room = 1;
         h = prev + $urandom_range(1, room);
         if ($urandom_range(0, 40) == 0) h = prev;
         load_entry(i, h, ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(0, 25600),
                    $urandom_range(0, 65535));
         if (h > prev || i == 0) begin
            profile[i] = h;
            profile_len = i + 1;
            prev = h;
         end else begin
            break;
         end
      end
   endtask

   task automatic ask_profile();
      int top, k, q;
      top = (profile_len > 0) ? profile[profile_len-1] : 1000;
      k = $urandom_range(0, profile_len > 0 ? profile_len - 1 : 0);
      case ($urandom_range(0, 9))
         0: q = 0;
         1: q = profile[k];
         2: q = profile[k] + 1;
         3: q = (profile[k] > 1) ? profile[k] - 1 : 1;
         4: q = (top < HEIGHT_MAX) ? $urandom_range(top + 1, HEIGHT_MAX) : top;
         5: q = $urandom_range(0, HEIGHT_MAX);
         default: q = $urandom_range(1, top);
      endcase
      ask_height(q);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      ask_height(100);
      ask_height(0);
      load_entry(1, 500, 256, 0);
      load_entry(0, 0, 256, 0);
      load_entry(0, 0, 0, 0);
      load_entry(1, 1000, 25600, 9000);
      load_entry(2, 1000, 256, 0);
      load_entry(2, 3000, 32767, 18000);
      load_entry(3, 9000, 12800, 27000);
      load_entry(4, HEIGHT_MAX, 5000, 65535);
      ask_height(500);
      ask_height(1000);
      ask_height(2000);
      ask_height(8999);
      ask_height(HEIGHT_MAX);
      load_entry(4, 4000000, 100, 35999);
      ask_height(4000001);
      ask_height(HEIGHT_MAX);
      load_entry(0, 2000, 25600, 4500);
      ask_height(700);
      ask_height(3000);
      for (int i = 1; i < 64; i++) load_entry(i, 2000 + i * 60000, i * 400, i * 571);
      ask_height(2000 + 63 * 60000);
      ask_height(2000 + 40 * 60000 + 12345);

      while (sent < ITEM_TARGET) begin
         if (sent > ITEM_TARGET - 200) gaps_on = 0;
         case ($urandom_range(0, 9))
            0, 1: build_profile();
            2: send_item($urandom_range(0, 1), $urandom_range(0, 63),
                         $urandom_range(0, HEIGHT_MAX), $urandom_range(0, 32767),
                         $urandom_range(0, 65535), $urandom_range(0, HEIGHT_MAX));
            default: repeat ($urandom_range(1, 8)) ask_profile();
         endcase
      end
      start <= 0;

      forever begin
         @(negedge clock);
         if (pending_count == 0) break;
      end
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("wind_profile_interpolator_unit regression: pass");
      end else begin
         $display("wind_profile_interpolator_unit regression: fail");
      end
      $finish;
   end

endmodule
